>>> hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, codes and the UTF-8 encoder shared by the UTF-16 to UTF-8 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int MAX_BEATS   = 4;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   // Offset of the supplementary planes, expressed on bits [20:10] of a code point.
   localparam logic [10:0] SUPP_BASE_HI = 11'h040;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_HIGH_ERR = 2'd1,
      ST_LOW_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  data;
   } result_type;

   // One queued job: up to four beats and the index of the last one.
   typedef struct packed {
      logic [1:0]                 last_idx;
      result_type [MAX_BEATS-1:0] res;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic [1:0]                 last_idx;
      logic [MAX_BEATS-1:0][7:0] bytes;
   } enc_type;

   function automatic enc_type encode_cp(input logic [20:0] cp);
      enc_type e;
      e.bytes = '0;
      if (cp[20:7] == 14'd0) begin
         e.last_idx = 2'd0;
         e.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp[20:11] == 10'd0) begin
         e.last_idx = 2'd1;
         e.bytes[0] = {3'b110, cp[10:6]};
         e.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp[20:16] == 5'd0) begin
         e.last_idx = 2'd2;
         e.bytes[0] = {4'b1110, cp[15:12]};
         e.bytes[1] = {2'b10, cp[11:6]};
         e.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         e.last_idx = 2'd3;
         e.bytes[0] = {5'b11110, cp[20:18]};
         e.bytes[1] = {2'b10, cp[17:12]};
         e.bytes[2] = {2'b10, cp[11:6]};
         e.bytes[3] = {2'b10, cp[5:0]};
      end
      return e;
   endfunction

endpackage

`default_nettype wire

>>> hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts key events, tracks a held high surrogate and builds the full list
// of result beats for each event as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic                  is_key_event,
   input  wire logic                  key_down,
   input  wire logic [15:0]           code_unit,
   input  wire u16u8_pkg::queue_status_type q_status,
   output logic                       push,
   output u16u8_pkg::entry_type       push_entry
);

   logic       pending_valid_ff, pending_valid_in;
   logic [9:0] pending_high_bits_ff, pending_high_bits_in;

   logic                        accept, drop, is_high, is_low, pair;
   logic [20:0]                 cp;
   u16u8_pkg::enc_type          enc;
   u16u8_pkg::result_type [3:0] lst;
   logic [2:0]                  lst_cnt, total;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign drop     = !is_key_event || !key_down || (code_unit == 16'd0);
   assign is_high  = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
   assign is_low   = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);
   assign pair     = pending_valid_ff && is_low;

   // A pair is 0x10000 + (high << 10) + low, so only bits [20:10] need an add.
   assign cp  = pair ? {11'({1'b0, pending_high_bits_ff}) + u16u8_pkg::SUPP_BASE_HI,
                        code_unit[9:0]}
                     : {5'd0, code_unit};
   assign enc = u16u8_pkg::encode_cp(cp);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lst[i] = '{status: u16u8_pkg::ST_DATA, data: enc.bytes[i]};
      end
      lst_cnt = 3'({1'b0, enc.last_idx}) + 3'd1;
      if (pair) begin
         lst_cnt = 3'({1'b0, enc.last_idx}) + 3'd1;
      end else if (is_high) begin
         lst_cnt = 3'd0;
      end else if (is_low) begin
         lst[0]  = '{status: u16u8_pkg::ST_LOW_ERR, data: 8'd0};
         lst_cnt = 3'd1;
      end

      // A held high surrogate that is not completed reports an error first.
      if (pending_valid_ff && !pair) begin
         push_entry.res[0] = '{status: u16u8_pkg::ST_HIGH_ERR, data: 8'd0};
         push_entry.res[1] = lst[0];
         push_entry.res[2] = lst[1];
         push_entry.res[3] = lst[2];
         total = lst_cnt + 3'd1;
      end else begin
         push_entry.res = lst;
         total = lst_cnt;
      end
      push_entry.last_idx = 2'(total - 3'd1);
   end

   assign push = accept && !drop && (total != 3'd0);

   always_comb begin
      pending_valid_in     = pending_valid_ff;
      pending_high_bits_in = pending_high_bits_ff;
      if (accept && !drop) begin
         if (is_high && !pair) begin
            pending_valid_in     = 1'b1;
            pending_high_bits_in = code_unit[9:0];
         end else begin
            pending_valid_in     = 1'b0;
            pending_high_bits_in = 10'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_valid_ff     <= 1'b0;
         pending_high_bits_ff <= 10'd0;
      end else begin
         pending_valid_ff     <= pending_valid_in;
         pending_high_bits_ff <= pending_high_bits_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Small FIFO of beat lists between the classifier and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_queue #(
   parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire u16u8_pkg::entry_type     push_entry,
   input  wire logic                     pop,
   output u16u8_pkg::entry_type          head,
   output u16u8_pkg::queue_status_type   q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u16u8_pkg::entry_type store [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head               = store[rd_ptr_ff];
   assign q_status.full      = (count_ff == CNT_W'(DEPTH));
   assign q_status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the beats of the queue head into the output register, one per cycle unless a held beat waits on out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire u16u8_pkg::entry_type     head,
   input  wire u16u8_pkg::queue_status_type q_status,
   output logic                          pop,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output u16u8_pkg::status_type         out_status,
   output logic [7:0]                    out_data,
   output logic                          out_last
);

   logic [1:0]            beat_ff, beat_in;
   logic                  valid_ff, valid_in;
   u16u8_pkg::result_type res_ff;
   logic                  last_ff;
   logic                  load, is_last;

   assign load    = q_status.not_empty && (!valid_ff || out_ready);
   assign is_last = (beat_ff == head.last_idx);
   assign pop     = load && is_last;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = is_last ? 2'd0 : beat_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff  <= head.res[beat_ff];
         last_ff <= is_last;
      end
   end

   assign out_valid  = valid_ff;
   assign out_status = res_ff.status;
   assign out_data   = res_ff.data;
   assign out_last   = last_ff;

endmodule

`default_nettype wire

>>> hdl/utf16_key_event_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// utf16_key_event_to_utf8_unit
// Converts key events carrying UTF-16 code units into a UTF-8 byte stream.
// ----------------------------------------------------------------------------
// Input channel (req_): one key event per beat. Events that are not key
// presses, or that carry a zero unit, are consumed silently. A high
// surrogate is held until the next unit arrives.
// Output channel (rsp_): one UTF-8 byte or error code per beat; tlast marks
// the final beat caused by one event. An error beat carries a zero byte.
// The front stage accepts one event per cycle while the job queue has room
// and turns it into a list of 1 to 4 beats, or none for a high surrogate
// that is held. The back stage sends one beat per cycle while rsp_tready
// is high, so the output port limits sustained throughput. Each event's
// beats pass through the job queue and then the output register.
// When rsp_tready is low the output register holds its beat, the queue
// fills, and req_tready drops once QUEUE_DEPTH jobs wait.
// Reset clears the held surrogate, the queue and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_key_event_to_utf8_unit #(
   parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] code_unit
   input  wire logic [1:0]  req_tuser,   // [0] is_key_event, [1] key_down
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] utf8_byte
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast    // last_of_run
);

   logic                        push, pop;
   u16u8_pkg::entry_type        push_entry, head;
   u16u8_pkg::queue_status_type q_status;
   u16u8_pkg::status_type       out_status;

   u16u8_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .is_key_event (req_tuser[0]),
      .key_down     (req_tuser[1]),
      .code_unit    (req_tdata),
      .q_status     (q_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_status (out_status),
      .out_data   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = out_status;

endmodule

`default_nettype wire

>>> hdl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the result stream of the UTF-16 to UTF-8 unit.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [1:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // The result stream starts empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat present right after reset");

   // A stalled beat stays in place.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // Error beats carry no byte.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != u16u8_pkg::ST_DATA) |-> rsp_tdata == 8'd0)
      else $error("error beat with nonzero byte");

   // An unpaired low surrogate ends its run.
   a_low_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == u16u8_pkg::ST_LOW_ERR) |-> rsp_tlast)
      else $error("low surrogate error not last of run");

   // A run of data never ends on a lead byte.
   a_data_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == u16u8_pkg::ST_DATA) && rsp_tlast
      |-> (rsp_tdata[7] == 1'b0) || (rsp_tdata[7:6] == 2'b10))
      else $error("run ends on a UTF-8 lead byte");

endmodule

bind utf16_key_event_to_utf8_unit u16u8_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
